// ===== design/rrs_pkg.sv =====
package rrs_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam int ID_W    = 16;
    localparam int SLICE_W = 8;
    localparam int TICK_W  = 32;
    localparam int OP_W    = 3;
    localparam int SLOT_W  = 4;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd5;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd1;
    localparam logic [OP_W-1:0] OP_YIELD  = 3'd2;
    localparam logic [OP_W-1:0] OP_EXIT   = 3'd3;
    localparam logic [OP_W-1:0] OP_SETRUN = 3'd4;

    // per-slot task state codes
    localparam logic [1:0] ST_BLOCKED = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_EXITED  = 2'd3;

    // one slot table entry
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [1:0]         st;
        logic [SLICE_W-1:0] slice;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== design/rrs_ram.sv =====
module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, read-first, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== design/round_robin_time_slice_scheduler.sv =====
// Round-robin task scheduler with a time slice. A request (operation, slot,
// new_task_id, runnable) is taken when start is high and busy is low; the
// block then stays busy until it raises done for exactly one cycle with the
// updated selection on running_slot, running_task_id, idle, switched and
// tick_count. The receiver cannot stall: sample the result on the done cycle.
// Every request gives exactly one result. Add, set-runnable, exit while idle
// and unused codes go from S_EXEC to S_DONE, directly or via S_CUR_CHK; a tick,
// yield or exit that reschedules also runs the round-robin search (S_SCAN_RD,
// S_SCAN), because the slot table sits in a single-port RAM and the search
// probes one slot per cycle. busy falls the cycle after done, so a new
// request can be started then. slice_length is written through
// cfg_valid/cfg_data (cfg_ready is always high) and should only change while
// the block is idle. The slot table needs no clearing pass after reset: only
// entries of slots below the task count are ever used.
module round_robin_time_slice_scheduler #(
    parameter int MAX_TASKS = rrs_pkg::MAX_TASKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request side
    input  logic                         start,
    output logic                         busy,
    input  logic [rrs_pkg::OP_W-1:0]     operation,
    input  logic [rrs_pkg::SLOT_W-1:0]   slot,
    input  logic [rrs_pkg::ID_W-1:0]     new_task_id,
    input  logic                         runnable,
    // result side
    output logic                         done,
    output logic [rrs_pkg::SLOT_W-1:0]   running_slot,
    output logic [rrs_pkg::ID_W-1:0]     running_task_id,
    output logic                         idle,
    output logic                         switched,
    output logic [rrs_pkg::TICK_W-1:0]   tick_count,
    // configuration
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rrs_pkg::SLICE_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int CMP_W = (CNT_W > rrs_pkg::SLOT_W) ? CNT_W : rrs_pkg::SLOT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,  // waiting for start
        S_EXEC    = 6'b000010,  // decode, issue first table access
        S_CUR_CHK = 6'b000100,  // entry of current/addressed slot is back
        S_SCAN_RD = 6'b001000,  // issue first probe of the search
        S_SCAN    = 6'b010000,  // one slot examined per cycle
        S_DONE    = 6'b100000   // result strobe
    } state_t;

    state_t                       state_reg, state_next;

    // latched request
    logic [rrs_pkg::OP_W-1:0]     op_reg, op_next;
    logic [rrs_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [rrs_pkg::ID_W-1:0]     id_reg, id_next;
    logic                         run_reg, run_next;
    logic                         was_idle_reg, was_idle_next;
    logic [IDX_W-1:0]             was_cur_reg, was_cur_next;

    // scheduler state
    logic [IDX_W-1:0]             cur_reg, cur_next;
    logic [rrs_pkg::ID_W-1:0]     cur_id_reg, cur_id_next;
    logic                         idle_reg, idle_next;
    logic                         fresh_reg, fresh_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [rrs_pkg::TICK_W-1:0]   tick_reg, tick_next;
    logic [rrs_pkg::SLICE_W-1:0]  slice_len_reg, slice_len_next;

    // search and table access bookkeeping
    logic [IDX_W-1:0]             chk_reg, chk_next;
    logic [IDX_W-1:0]             probe_reg, probe_next;
    logic [IDX_W-1:0]             rdk_reg, rdk_next;
    logic [CNT_W-1:0]             seen_reg, seen_next;

    // slot table port
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_addr;
    rrs_pkg::entry_t              ram_wdata;
    rrs_pkg::entry_t              ram_rdata;

    logic                         accept;
    logic [IDX_W-1:0]             scan_start;
    logic [rrs_pkg::SLICE_W-1:0]  slice_dec;

    // Next slot index, wrapping at the task count
    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] k,
                                                  input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] k1;
        begin
            k1 = CNT_W'(k) + CNT_W'(1);
            wrap_inc = (k1 == n) ? '0 : IDX_W'(k1);
        end
    endfunction

    rrs_ram #(
        .WIDTH (rrs_pkg::ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign accept     = start && !busy;
    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    // a fresh search starts at slot 0, otherwise just after the current slot
    assign scan_start = fresh_reg ? '0 : wrap_inc(cur_reg, count_reg);
    assign slice_dec  = (ram_rdata.slice != '0) ? (ram_rdata.slice - 8'd1) : ram_rdata.slice;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        slot_next      = slot_reg;
        id_next        = id_reg;
        run_next       = run_reg;
        was_idle_next  = was_idle_reg;
        was_cur_next   = was_cur_reg;
        cur_next       = cur_reg;
        cur_id_next    = cur_id_reg;
        idle_next      = idle_reg;
        fresh_next     = fresh_reg;
        count_next     = count_reg;
        tick_next      = tick_reg;
        slice_len_next = slice_len_reg;
        chk_next       = chk_reg;
        probe_next     = probe_reg;
        rdk_next       = rdk_reg;
        seen_next      = seen_reg;
        ram_we         = 1'b0;
        ram_addr       = chk_reg;
        ram_wdata      = ram_rdata;

        if (cfg_valid && cfg_ready)
        begin
            slice_len_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = operation;
                    slot_next     = slot;
                    id_next       = new_task_id;
                    run_next      = runnable;
                    was_idle_next = idle_reg;
                    was_cur_next  = cur_reg;
                    if (operation == rrs_pkg::OP_TICK)
                    begin
                        tick_next = tick_reg + 32'd1;
                    end
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                chk_next   = cur_reg;
                case (op_reg)
                    rrs_pkg::OP_ADD:
                    begin
                        // table full: ignored
                        if (count_reg < CNT_MAX)
                        begin
                            ram_we          = 1'b1;
                            ram_addr        = IDX_W'(count_reg);
                            ram_wdata.id    = id_reg;
                            ram_wdata.st    = run_reg ? rrs_pkg::ST_READY
                                                      : rrs_pkg::ST_BLOCKED;
                            ram_wdata.slice = '0;
                            count_next      = count_reg + CNT_W'(1);
                        end
                    end
                    rrs_pkg::OP_TICK, rrs_pkg::OP_YIELD:
                    begin
                        if (idle_reg)
                        begin
                            state_next = S_SCAN_RD;
                        end
                        else
                        begin
                            ram_addr   = cur_reg;
                            state_next = S_CUR_CHK;
                        end
                    end
                    rrs_pkg::OP_EXIT:
                    begin
                        // exit while idle is ignored
                        if (!idle_reg)
                        begin
                            ram_addr   = cur_reg;
                            state_next = S_CUR_CHK;
                        end
                    end
                    rrs_pkg::OP_SETRUN:
                    begin
                        if (CMP_W'(slot_reg) < CMP_W'(count_reg))
                        begin
                            ram_addr   = IDX_W'(slot_reg);
                            chk_next   = IDX_W'(slot_reg);
                            state_next = S_CUR_CHK;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_CUR_CHK:
            begin
                state_next = S_DONE;
                case (op_reg)
                    rrs_pkg::OP_TICK:
                    begin
                        if (ram_rdata.st == rrs_pkg::ST_RUNNING)
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.slice = slice_dec;
                            if (slice_dec == '0)
                            begin
                                // slice used up
                                ram_wdata.st = rrs_pkg::ST_READY;
                                state_next   = S_SCAN_RD;
                            end
                        end
                        else
                        begin
                            // current task was blocked under us
                            state_next = S_SCAN_RD;
                        end
                    end
                    rrs_pkg::OP_YIELD:
                    begin
                        if (ram_rdata.st == rrs_pkg::ST_RUNNING)
                        begin
                            ram_we       = 1'b1;
                            ram_wdata.st = rrs_pkg::ST_READY;
                        end
                        state_next = S_SCAN_RD;
                    end
                    rrs_pkg::OP_EXIT:
                    begin
                        ram_we          = 1'b1;
                        ram_wdata.st    = rrs_pkg::ST_EXITED;
                        ram_wdata.slice = '0;
                        state_next      = S_SCAN_RD;
                    end
                    rrs_pkg::OP_SETRUN:
                    begin
                        if (ram_rdata.st != rrs_pkg::ST_EXITED)
                        begin
                            if (!run_reg)
                            begin
                                ram_we       = 1'b1;
                                ram_wdata.st = rrs_pkg::ST_BLOCKED;
                            end
                            else if (ram_rdata.st == rrs_pkg::ST_BLOCKED)
                            begin
                                ram_we       = 1'b1;
                                ram_wdata.st = rrs_pkg::ST_READY;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SCAN_RD:
            begin
                if (count_reg == '0)
                begin
                    idle_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_addr   = scan_start;
                    probe_next = scan_start;
                    rdk_next   = wrap_inc(scan_start, count_reg);
                    seen_next  = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // ram_rdata holds the entry of probe_reg
                if (ram_rdata.st == rrs_pkg::ST_READY ||
                    ram_rdata.st == rrs_pkg::ST_RUNNING)
                begin
                    ram_we          = 1'b1;
                    ram_addr        = probe_reg;
                    ram_wdata.st    = rrs_pkg::ST_RUNNING;
                    ram_wdata.slice = slice_len_reg;
                    cur_next        = probe_reg;
                    cur_id_next     = ram_rdata.id;
                    idle_next       = 1'b0;
                    fresh_next      = 1'b0;
                    state_next      = S_DONE;
                end
                else if (seen_reg + CNT_W'(1) == count_reg)
                begin
                    // nothing runnable
                    idle_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_addr   = rdk_reg;
                    probe_next = rdk_reg;
                    rdk_next   = wrap_inc(rdk_reg, count_reg);
                    seen_next  = seen_reg + CNT_W'(1);
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            idle_reg      <= 1'b1;
            fresh_reg     <= 1'b1;
            count_reg     <= '0;
            tick_reg      <= '0;
            slice_len_reg <= rrs_pkg::SLICE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            idle_reg      <= idle_next;
            fresh_reg     <= fresh_next;
            count_reg     <= count_next;
            tick_reg      <= tick_next;
            slice_len_reg <= slice_len_next;
        end
    end

    // payload and search registers, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        slot_reg     <= slot_next;
        id_reg       <= id_next;
        run_reg      <= run_next;
        was_idle_reg <= was_idle_next;
        was_cur_reg  <= was_cur_next;
        cur_id_reg   <= cur_id_next;
        chk_reg      <= chk_next;
        probe_reg    <= probe_next;
        rdk_reg      <= rdk_next;
        seen_reg     <= seen_next;
    end

    // result
    assign done            = (state_reg == S_DONE);
    assign idle            = idle_reg;
    assign running_slot    = idle_reg ? '0 : rrs_pkg::SLOT_W'(cur_reg);
    assign running_task_id = idle_reg ? '0 : cur_id_reg;
    assign tick_count      = tick_reg;
    assign switched        = (was_idle_reg != idle_reg) ||
                             (!idle_reg && (was_cur_reg != cur_reg));

    // a selected slot always lies inside the filled part of the table
    a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !idle_reg |-> (CNT_W'(cur_reg) < count_reg))
        else $error("current slot beyond task count");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("task count overflow");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("request accepted without going busy");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("busy held after result");

endmodule

// ===== tb/sv/round_robin_time_slice_scheduler_tb.sv =====
module round_robin_time_slice_scheduler_tb;

    localparam int NUM_SLOTS  = rrs_pkg::MAX_TASKS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    // codes 5..7 are unused: the block must just report the current selection
    localparam logic [rrs_pkg::OP_W-1:0] OP_RSVD_LO = 3'd5;
    localparam logic [rrs_pkg::OP_W-1:0] OP_RSVD_HI = 3'd7;

    // ------------------------------------------------------------------
    // Clock, reset and DUT pins
    // ------------------------------------------------------------------
    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [rrs_pkg::OP_W-1:0]      operation = rrs_pkg::OP_ADD;
    logic [rrs_pkg::SLOT_W-1:0]    slot = '0;
    logic [rrs_pkg::ID_W-1:0]      new_task_id = '0;
    logic                          runnable = 1'b0;
    logic                          done;
    logic [rrs_pkg::SLOT_W-1:0]    running_slot;
    logic [rrs_pkg::ID_W-1:0]      running_task_id;
    logic                          idle;
    logic                          switched;
    logic [rrs_pkg::TICK_W-1:0]    tick_count;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [rrs_pkg::SLICE_W-1:0]   cfg_data = '0;

    always #5 clk = ~clk;

    round_robin_time_slice_scheduler u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .slot            (slot),
        .new_task_id     (new_task_id),
        .runnable        (runnable),
        .done            (done),
        .running_slot    (running_slot),
        .running_task_id (running_task_id),
        .idle            (idle),
        .switched        (switched),
        .tick_count      (tick_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------
    // Stimulus queue: requests, slice-length writes and drain points.
    // A drain point holds the sender until every result is back.
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {
        STEP_REQ,
        STEP_CFG,
        STEP_DRAIN
    } step_kind_t;

    typedef struct packed {
        step_kind_t                    kind;
        logic [rrs_pkg::OP_W-1:0]      op;
        logic [rrs_pkg::SLOT_W-1:0]    sl;
        logic [rrs_pkg::ID_W-1:0]      id;
        logic                          run;
        logic [rrs_pkg::SLICE_W-1:0]   slice_len;
        logic [4:0]                    pause;    // idle cycles before presenting
    } sched_step_t;

    typedef struct packed {
        logic [rrs_pkg::SLOT_W-1:0]    sl;
        logic [rrs_pkg::ID_W-1:0]      id;
        logic                          is_idle;
        logic                          sw;
        logic [rrs_pkg::TICK_W-1:0]    ticks;
    } selection_t;

    sched_step_t request_q[$];
    selection_t  selection_q[$];   // expected selections, oldest first

    int unsigned adds_issued = 0;
    int unsigned exits_left  = 10;  // exits are permanent; ration them
    int unsigned err_cnt     = 0;
    int unsigned cycle_cnt   = 0;

    // handshake results of the last rising edge, seen by the driver
    logic req_taken = 1'b0;
    logic cfg_taken = 1'b0;

    // ------------------------------------------------------------------
    // Scheduler model: slot table, selection and tick counter
    // ------------------------------------------------------------------
    logic [rrs_pkg::ID_W-1:0]    m_ids   [NUM_SLOTS];
    logic [1:0]                  m_st    [NUM_SLOTS];
    logic [rrs_pkg::SLICE_W-1:0] m_slice [NUM_SLOTS];
    int unsigned                 m_count = 0;
    logic [rrs_pkg::SLOT_W-1:0]  m_cur   = '0;
    logic                        m_idle  = 1'b1;
    logic                        m_fresh = 1'b1;   // first scan starts at slot 0
    logic [rrs_pkg::TICK_W-1:0]  m_ticks = '0;
    logic [rrs_pkg::SLICE_W-1:0] m_slice_len = rrs_pkg::SLICE_RESET;

    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            m_ids[i]   = '0;
            m_st[i]    = rrs_pkg::ST_BLOCKED;
            m_slice[i] = '0;
        end
    end

    // round-robin scan from the slot after the current one (slot 0 when fresh),
    // wrapping over the added slots; selects idle when nothing is ready or running
    function automatic void select_next();
        int unsigned first;
        int unsigned k;
        if (m_count == 0)
        begin
            m_idle = 1'b1;
            return;
        end
        first = m_fresh ? 0 : int'(m_cur) + 1;
        for (int i = 0; i < m_count; i++)
        begin
            k = (first + i) % m_count;
            if (m_st[k] == rrs_pkg::ST_READY || m_st[k] == rrs_pkg::ST_RUNNING)
            begin
                m_cur      = rrs_pkg::SLOT_W'(k);
                m_st[k]    = rrs_pkg::ST_RUNNING;
                m_slice[k] = m_slice_len;
                m_idle     = 1'b0;
                m_fresh    = 1'b0;
                return;
            end
        end
        m_idle = 1'b1;
    endfunction

    function automatic selection_t schedule_step(logic [rrs_pkg::OP_W-1:0] op,
                                                 logic [rrs_pkg::SLOT_W-1:0] sl,
                                                 logic [rrs_pkg::ID_W-1:0] id,
                                                 logic run);
        logic                       was_idle;
        logic [rrs_pkg::SLOT_W-1:0] was_cur;
        selection_t                 r;
        was_idle = m_idle;
        was_cur  = m_cur;
        case (op)
            rrs_pkg::OP_ADD:
            begin
                // full table: silently dropped
                if (m_count < NUM_SLOTS)
                begin
                    m_ids[m_count]   = id;
                    m_st[m_count]    = run ? rrs_pkg::ST_READY : rrs_pkg::ST_BLOCKED;
                    m_slice[m_count] = '0;
                    m_count++;
                end
            end
            rrs_pkg::OP_TICK:
            begin
                m_ticks = m_ticks + 1'b1;
                if (m_idle)
                begin
                    select_next();
                end
                else if (m_st[m_cur] == rrs_pkg::ST_RUNNING)
                begin
                    // a zero slice behaves as a slice of one
                    if (m_slice[m_cur] != 0)
                        m_slice[m_cur] = m_slice[m_cur] - 1'b1;
                    if (m_slice[m_cur] == 0)
                    begin
                        m_st[m_cur] = rrs_pkg::ST_READY;
                        select_next();
                    end
                end
                else
                begin
                    // current task was blocked under us: reschedule now
                    select_next();
                end
            end
            rrs_pkg::OP_YIELD:
            begin
                if (!m_idle && m_st[m_cur] == rrs_pkg::ST_RUNNING)
                    m_st[m_cur] = rrs_pkg::ST_READY;
                select_next();
            end
            rrs_pkg::OP_EXIT:
            begin
                if (!m_idle)
                begin
                    m_st[m_cur]    = rrs_pkg::ST_EXITED;
                    m_slice[m_cur] = '0;
                    select_next();
                end
            end
            rrs_pkg::OP_SETRUN:
            begin
                if (sl < m_count && m_st[sl] != rrs_pkg::ST_EXITED)
                begin
                    if (!run)
                        m_st[sl] = rrs_pkg::ST_BLOCKED;
                    else if (m_st[sl] == rrs_pkg::ST_BLOCKED)
                        m_st[sl] = rrs_pkg::ST_READY;
                end
            end
            default: ;
        endcase
        r.is_idle = m_idle;
        r.sl      = m_idle ? '0 : m_cur;
        r.id      = m_idle ? '0 : m_ids[m_cur];
        if (was_idle && m_idle)
            r.sw = 1'b0;
        else if (was_idle != m_idle)
            r.sw = 1'b1;
        else
            r.sw = (was_cur != m_cur);
        r.ticks = m_ticks;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_req(logic [rrs_pkg::OP_W-1:0] op, logic [rrs_pkg::SLOT_W-1:0] sl,
                            logic [rrs_pkg::ID_W-1:0] id, logic run, logic [4:0] pause);
        sched_step_t s;
        s.kind      = STEP_REQ;
        s.op        = op;
        s.sl        = sl;
        s.id        = id;
        s.run       = run;
        s.slice_len = '0;
        s.pause     = pause;
        if (op == rrs_pkg::OP_ADD)
            adds_issued++;
        request_q.push_back(s);
    endtask

    task automatic push_ctl(step_kind_t kind, logic [rrs_pkg::SLICE_W-1:0] val);
        sched_step_t s;
        s           = '0;
        s.kind      = kind;
        s.slice_len = val;
        request_q.push_back(s);
    endtask

    function automatic logic [rrs_pkg::OP_W-1:0] OP_TYPE_RSVD();
        return rrs_pkg::OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
    endfunction

    // tick_w: ticks per thousand; calm: no sender gaps
    task automatic push_random(int unsigned tick_w, bit calm);
        int unsigned              roll;
        logic [rrs_pkg::OP_W-1:0] op;
        logic [4:0]               pause;
        roll = $urandom_range(0, 999);
        if (adds_issued < NUM_SLOTS && $urandom_range(0, 7) == 0)
            op = rrs_pkg::OP_ADD;
        else if (roll < tick_w)
            op = rrs_pkg::OP_TICK;
        else if (roll < tick_w + 100)
            op = rrs_pkg::OP_YIELD;
        else if (roll < tick_w + 120)
            op = rrs_pkg::OP_ADD;             // mostly lands on a full table
        else if (roll < tick_w + 140)
            op = OP_TYPE_RSVD();
        else if (roll < tick_w + 155 && exits_left > 0)
        begin
            op = rrs_pkg::OP_EXIT;
            exits_left--;
        end
        else
            op = rrs_pkg::OP_SETRUN;
        pause = 5'd0;
        if (!calm && $urandom_range(0, 7) == 0)
            pause = 5'($urandom_range(1, 19));
        push_req(op, rrs_pkg::SLOT_W'($urandom), rrs_pkg::ID_W'($urandom),
                 $urandom_range(0, 9) < 6, pause);
    endtask

    // ------------------------------------------------------------------
    // Driver: changes inputs on the falling edge only. start and cfg_valid
    // each get exactly one nonblocking update per edge.
    // ------------------------------------------------------------------
    int unsigned gap_cnt = 0;

    always @(negedge clk)
    begin
        logic nxt_start;
        logic nxt_cfg;
        nxt_start = start;
        nxt_cfg   = cfg_valid;
        if (req_taken)
            nxt_start = 1'b0;
        if (cfg_taken)
            nxt_cfg = 1'b0;
        if (rst_n && !nxt_start && !nxt_cfg && request_q.size() > 0)
        begin
            case (request_q[0].kind)
                STEP_REQ:
                begin
                    if (gap_cnt < request_q[0].pause)
                    begin
                        gap_cnt++;
                    end
                    else
                    begin
                        gap_cnt     = 0;
                        operation   <= request_q[0].op;
                        slot        <= request_q[0].sl;
                        new_task_id <= request_q[0].id;
                        runnable    <= request_q[0].run;
                        nxt_start   = 1'b1;
                        void'(request_q.pop_front());
                    end
                end
                STEP_CFG:
                begin
                    // slice length only changes with the block quiet
                    if (selection_q.size() == 0 && !busy)
                    begin
                        cfg_data <= request_q[0].slice_len;
                        nxt_cfg  = 1'b1;
                        void'(request_q.pop_front());
                    end
                end
                default:
                begin
                    if (selection_q.size() == 0)
                        void'(request_q.pop_front());
                end
            endcase
        end
        start     <= nxt_start;
        cfg_valid <= nxt_cfg;
    end

    // ------------------------------------------------------------------
    // Monitor: on the rising edge, check a result strobe against the oldest
    // expected selection, then apply a config write, then predict for an
    // accepted request. A strobe on the edge that takes a new request
    // belongs to the previous one, hence the order.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
            err_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin
        selection_t exp_sel;
        req_taken <= rst_n && start && !busy;
        cfg_taken <= rst_n && cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (done)
            begin
                if (selection_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual slot %0h id %0h",
                             $time, running_slot, running_task_id);
                    err_cnt++;
                end
                else
                begin
                    exp_sel = selection_q.pop_front();
                    check_field("running_slot", 32'(exp_sel.sl), 32'(running_slot));
                    check_field("running_task_id", 32'(exp_sel.id), 32'(running_task_id));
                    check_field("idle", 32'(exp_sel.is_idle), 32'(idle));
                    check_field("switched", 32'(exp_sel.sw), 32'(switched));
                    check_field("tick_count", exp_sel.ticks, tick_count);
                end
            end
            if (cfg_valid && cfg_ready)
                m_slice_len = cfg_data;
            if (start && !busy)
                selection_q.push_back(schedule_step(operation, slot, new_task_id, runnable));
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        // directed: empty table, unused codes, blocked current task,
        // exited slot, yield with a single ready task, id extremes
        push_req(rrs_pkg::OP_TICK,   4'd0,  16'h1234, 1'b1, 5'd0);  // tick with nothing added
        push_req(rrs_pkg::OP_YIELD,  4'd3,  16'h0000, 1'b0, 5'd0);  // yield while idle
        push_req(rrs_pkg::OP_EXIT,   4'd7,  16'hFFFF, 1'b1, 5'd0);  // exit while idle
        push_req(rrs_pkg::OP_SETRUN, 4'd15, 16'h0000, 1'b1, 5'd0);  // slot not yet added
        push_req(OP_RSVD_LO,         4'd0,  16'h0000, 1'b0, 5'd0);
        push_req(OP_RSVD_LO + 3'd1,  4'd5,  16'hAAAA, 1'b1, 5'd0);
        push_req(OP_RSVD_HI,         4'd10, 16'h5555, 1'b0, 5'd0);
        push_req(rrs_pkg::OP_ADD,    4'd0,  16'hFFFF, 1'b0, 5'd0);  // slot 0, blocked
        push_req(rrs_pkg::OP_TICK,   4'd0,  16'h0000, 1'b0, 5'd0);  // nothing ready: stay idle
        push_req(rrs_pkg::OP_ADD,    4'd0,  16'h0000, 1'b1, 5'd0);  // slot 1, ready
        push_req(rrs_pkg::OP_TICK,   4'd0,  16'h0000, 1'b0, 5'd0);  // first scan from slot 0
        push_req(rrs_pkg::OP_SETRUN, 4'd1,  16'h0000, 1'b0, 5'd0);  // block the running task
        push_req(rrs_pkg::OP_TICK,   4'd0,  16'h0000, 1'b0, 5'd0);  // rescheduled at once: idle
        push_req(rrs_pkg::OP_SETRUN, 4'd0,  16'h0000, 1'b1, 5'd0);
        push_req(rrs_pkg::OP_YIELD,  4'd0,  16'h0000, 1'b0, 5'd0);  // leaves idle via yield
        push_req(rrs_pkg::OP_SETRUN, 4'd0,  16'h0000, 1'b1, 5'd0);  // running stays running
        push_req(rrs_pkg::OP_YIELD,  4'd0,  16'h0000, 1'b0, 5'd0);  // lone ready task re-picked
        push_req(rrs_pkg::OP_EXIT,   4'd0,  16'h0000, 1'b0, 5'd0);
        push_req(rrs_pkg::OP_SETRUN, 4'd0,  16'h0000, 1'b1, 5'd0);  // exited slot: no effect
        push_req(rrs_pkg::OP_ADD,    4'd0,  16'h5A5A, 1'b1, 5'd0);
        push_req(rrs_pkg::OP_TICK,   4'd0,  16'h0000, 1'b0, 5'd0);
        push_req(rrs_pkg::OP_YIELD,  4'd0,  16'h0000, 1'b1, 5'd0);

        // random phases, one slice length each; table fills early on
        for (int i = 0; i < 250; i++) push_random(450, 1'b0);
        push_ctl(STEP_CFG, 8'd1);
        for (int i = 0; i < 200; i++) push_random(450, 1'b0);
        push_ctl(STEP_DRAIN, '0);
        for (int i = 0; i < 20; i++) push_random(450, 1'b0);
        push_ctl(STEP_CFG, 8'd255);
        for (int i = 0; i < 240; i++) push_random(800, 1'b0);   // long slices need ticks
        push_ctl(STEP_CFG, 8'd0);
        for (int i = 0; i < 200; i++) push_random(450, 1'b0);
        push_ctl(STEP_CFG, 8'd2);
        for (int i = 0; i < 200; i++) push_random(500, 1'b0);
        push_ctl(STEP_CFG, rrs_pkg::SLICE_W'($urandom_range(3, 254)));
        for (int i = 0; i < 200; i++) push_random(500, 1'b1);   // back to back to the end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || start || cfg_valid || selection_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
